// ===== rtl/core/wpscm_pkg.sv =====
`default_nettype none
package wpscm_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 5;

  localparam logic [11:0] WheelLengthRst = 12'd2100;
  localparam logic [7:0]  DebounceRst    = 8'd10;
  localparam logic [7:0]  SleepRst       = 8'd30;
  localparam logic [7:0]  StepsRst       = 8'd10;
  localparam logic [15:0] AvgMinRst      = 16'd10;

  localparam logic [31:0] SpeedScale   = 32'd15625;
  localparam logic [31:0] CadenceConst = 32'd9375000;
  localparam logic [31:0] KiloConst    = 32'd1000;
  // ceil(2^38 / 1000): n / 1000 == (n * KiloRecip) >> 38 for any 32-bit n
  localparam logic [28:0] KiloRecip    = 29'd274877907;

  localparam logic [2:0] RegWheel  = 3'd0;
  localparam logic [2:0] RegDeb    = 3'd1;
  localparam logic [2:0] RegSleep  = 3'd2;
  localparam logic [2:0] RegSteps  = 3'd3;
  localparam logic [2:0] RegAvgMin = 3'd4;

  typedef enum logic [2:0] {
    FnTick   = 3'd0,
    FnPin    = 3'd1,
    FnStep   = 3'd2,
    FnAct    = 3'd3,
    FnPause  = 3'd4,
    FnReset  = 3'd5,
    FnQuery  = 3'd6,
    FnNop    = 3'd7
  } func_e;

  typedef enum logic [2:0] {
    QSpeed   = 3'd0,
    QTrack   = 3'd1,
    QTime    = 3'd2,
    QAvg     = 3'd3,
    QCadence = 3'd4,
    QDist    = 3'd5,
    QWheel   = 3'd6,
    QZero    = 3'd7
  } qsel_e;

  // divider operand sources
  typedef enum logic [2:0] {
    DvSpeed   = 3'd0,
    DvTime    = 3'd1,
    DvAvg     = 3'd2,
    DvCadence = 3'd3
  } dsrc_e;

  // what to do with the divider result
  typedef enum logic [1:0] {
    ResValue = 2'd0,
    ResSecs  = 2'd1,
    ResDist  = 2'd2,
    ResAccum = 2'd3
  } rdst_e;

  typedef struct packed {
    logic  event_en;   // apply single-cycle event update
    logic  div_start;
    dsrc_e div_src;
    logic  res_en;     // capture divider result
    rdst_e res_dst;
    logic  val_direct; // direct value for non-divide queries
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic secs_gt;     // track seconds exceed minimum
    logic speed_ok;    // moving with nonzero wheel period
    logic cad_ok;      // moving with nonzero pedal period
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/wpscm_div.sv =====
`default_nettype none
module wpscm_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] num_i,
  input  wire logic [31:0] den_i,
  output logic             done_o,
  output logic [31:0]      quo_o
);
  // signed 32-bit truncating division, one quotient bit per cycle
  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, neg_q, neg_d, zero_q, zero_d, done_q, done_d;
  logic [32:0] trial;
  logic [31:0] na, nb;

  assign na = num_i[31] ? (32'd0 - num_i) : num_i;
  assign nb = den_i[31] ? (32'd0 - den_i) : den_i;
  assign trial = {rem_q, quo_q[31]} - {1'b0, den_q};

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; neg_d = neg_q; zero_d = zero_q; done_d = 1'b0;
    if (start_i) begin
      rem_d = '0; quo_d = na; den_d = nb; cnt_d = 6'd32; busy_d = 1'b1;
      neg_d = num_i[31] ^ den_i[31]; zero_d = (den_i == 32'd0);
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0]; quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]}; quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d; zero_q <= zero_d;
  end

  assign done_o = done_q;
  assign quo_o  = zero_q ? 32'd0 : (neg_q ? (32'd0 - quo_q) : quo_q);

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without busy");
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !done_d) else $error("done from idle");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/wpscm_dp.sv =====
`default_nettype none
module wpscm_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire wpscm_pkg::cmd_t   cmd_i,
  output wpscm_pkg::sts_t        sts_o,
  input  wire logic [2:0]        func_i,
  input  wire logic              wheel_low_i,
  input  wire logic              pedal_low_i,
  input  wire logic [2:0]        sel_i,
  input  wire logic [11:0]       wheel_length_i,
  input  wire logic [7:0]        debounce_i,
  input  wire logic [7:0]        sleep_reload_i,
  input  wire logic [7:0]        steps_i,
  input  wire logic [15:0]       avg_min_i,
  output logic [31:0]            value_o,
  output logic [7:0]             sleep_o,
  output logic                   moving_o
);
  logic [15:0] ic_q, ic_d;
  logic [31:0] wacc_q, wacc_d, pacc_q, pacc_d, wper_q, wper_d, pper_q, pper_d;
  logic [31:0] turns_q, turns_d, tsteps_q, tsteps_d, tdist_q, tdist_d;
  logic        mov_q, mov_d, pau_q, pau_d;
  logic [7:0]  whold_q, whold_d, phold_q, phold_d, sleep_q, sleep_d;
  logic [31:0] secs_q, val_q, track_q, res_q;
  logic [31:0] dnum, dden, quo;
  logic [31:0] direct;
  logic [15:0] ic_w;
  logic        done;
  logic [31:0] tabs, kilo;
  logic [60:0] kprod_q;
  logic        kneg_q;

  // track length registered; one multiply per path
  always_ff @(posedge clk_i) track_q <= turns_q * {20'd0, wheel_length_i};

  // track / 1000 by reciprocal multiply, valid in the cycle after track_q
  assign tabs = track_q[31] ? (32'd0 - track_q) : track_q;
  always_ff @(posedge clk_i) begin
    kprod_q <= {29'd0, tabs} * {32'd0, wpscm_pkg::KiloRecip};
    kneg_q  <= track_q[31];
  end
  assign kilo = kneg_q ? (32'd0 - {9'd0, kprod_q[60:38]}) : {9'd0, kprod_q[60:38]};

  always_comb begin
    dnum = track_q; dden = 32'd1;
    case (cmd_i.div_src)
      wpscm_pkg::DvSpeed: begin
        dnum = wpscm_pkg::SpeedScale * {20'd0, wheel_length_i}; dden = wper_q;
      end
      wpscm_pkg::DvTime:    begin dnum = tsteps_q; dden = {24'd0, steps_i}; end
      wpscm_pkg::DvAvg:     begin dnum = track_q; dden = secs_q; end
      wpscm_pkg::DvCadence: begin dnum = wpscm_pkg::CadenceConst; dden = pper_q; end
      default: ;
    endcase
  end

  wpscm_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(dnum), .den_i(dden),
    .done_o(done), .quo_o(quo)
  );

  always_comb begin
    case (sel_i)
      wpscm_pkg::QSpeed:   direct = 32'd0;
      wpscm_pkg::QTrack:   direct = track_q;
      wpscm_pkg::QTime:    direct = secs_q;
      wpscm_pkg::QAvg:     direct = 32'd0 - {24'd0, steps_i};
      wpscm_pkg::QCadence: direct = 32'd0;
      wpscm_pkg::QDist:    direct = res_q + tdist_q;
      wpscm_pkg::QWheel:   direct = {20'd0, wheel_length_i};
      default:             direct = 32'd0;
    endcase
  end

  always_comb begin
    ic_d = ic_q; wacc_d = wacc_q; pacc_d = pacc_q; wper_d = wper_q; pper_d = pper_q;
    turns_d = turns_q; tsteps_d = tsteps_q; tdist_d = tdist_q; mov_d = mov_q;
    pau_d = pau_q; whold_d = whold_q; phold_d = phold_q; sleep_d = sleep_q;
    ic_w = 16'd0;
    if (cmd_i.event_en) begin
      case (func_i)
        wpscm_pkg::FnTick: begin
          ic_d = ic_q + 16'd1;
          if (ic_d == 16'd0) begin
            wacc_d = '0; pacc_d = '0; wper_d = '0; pper_d = '0; mov_d = 1'b0;
            if (sleep_q != 8'd0) sleep_d = sleep_q - 8'd1;
          end
        end
        wpscm_pkg::FnPin: begin
          ic_w = ic_q;
          if (wheel_low_i && whold_q == 8'd0) begin
            whold_d = debounce_i; turns_d = turns_q + 32'd1;
            if (mov_q) wper_d = wacc_q + {16'd0, ic_w};
            pacc_d = pacc_q + {16'd0, ic_w};
            ic_w = 16'd0; wacc_d = '0;
          end
          if (pedal_low_i && phold_q == 8'd0) begin
            phold_d = debounce_i;
            if (mov_q) pper_d = pacc_d + {16'd0, ic_w};
            wacc_d = wacc_d + {16'd0, ic_w};
            ic_w = 16'd0; pacc_d = '0;
          end
          ic_d = ic_w; mov_d = 1'b1; sleep_d = sleep_reload_i;
        end
        wpscm_pkg::FnStep: begin
          if (whold_q != 8'd0) whold_d = whold_q - 8'd1;
          if (phold_q != 8'd0) phold_d = phold_q - 8'd1;
          if (!pau_q && mov_q) tsteps_d = tsteps_q + 32'd1;
        end
        wpscm_pkg::FnAct:   sleep_d = sleep_reload_i;
        wpscm_pkg::FnPause: pau_d = !pau_q;
        default: ;
      endcase
    end
    if (cmd_i.res_en && cmd_i.res_dst == wpscm_pkg::ResAccum) begin
      pau_d = 1'b0; tdist_d = tdist_q + kilo; turns_d = '0; tsteps_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q <= '0; wacc_q <= '0; pacc_q <= '0; wper_q <= '0; pper_q <= '0;
      turns_q <= '0; tsteps_q <= '0; tdist_q <= '0; mov_q <= 1'b0; pau_q <= 1'b0;
      whold_q <= wpscm_pkg::DebounceRst; phold_q <= wpscm_pkg::DebounceRst;
      sleep_q <= wpscm_pkg::SleepRst;
      value_o <= '0; sleep_o <= wpscm_pkg::SleepRst; moving_o <= 1'b0;
    end else begin
      ic_q <= ic_d; wacc_q <= wacc_d; pacc_q <= pacc_d; wper_q <= wper_d;
      pper_q <= pper_d; turns_q <= turns_d; tsteps_q <= tsteps_d; tdist_q <= tdist_d;
      mov_q <= mov_d; pau_q <= pau_d; whold_q <= whold_d; phold_q <= phold_d;
      sleep_q <= sleep_d;
      if (cmd_i.out_load) begin
        value_o <= val_q; sleep_o <= sleep_q; moving_o <= mov_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.event_en) val_q <= '0;
    else if (cmd_i.val_direct) val_q <= direct;
    else if (cmd_i.res_en && cmd_i.res_dst == wpscm_pkg::ResValue) val_q <= quo;
    if (cmd_i.res_en && cmd_i.res_dst == wpscm_pkg::ResSecs)
      secs_q <= (steps_i == 8'd0) ? 32'd0 : quo;
    if (cmd_i.res_en && cmd_i.res_dst == wpscm_pkg::ResDist) res_q <= kilo;
  end

  assign sts_o.div_done = done;
  assign sts_o.secs_gt  = $signed(secs_q) > $signed({16'd0, avg_min_i});
  assign sts_o.speed_ok = mov_q && (wper_q != 32'd0);
  assign sts_o.cad_ok   = mov_q && (pper_q != 32'd0);

`ifndef SYNTH
  a_hold_deb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.event_en && func_i == wpscm_pkg::FnPin) |=> mov_q)
    else $error("pin change must set moving");
  a_wrap_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.event_en && func_i == wpscm_pkg::FnTick && ic_q == 16'hFFFF) |=> !mov_q)
    else $error("wrap must clear moving");
  a_reset_trk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.res_en && cmd_i.res_dst == wpscm_pkg::ResAccum) |=> turns_q == 32'd0)
    else $error("track reset must clear turns");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/wpscm_ctrl.sv =====
`default_nettype none
module wpscm_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire logic [2:0]      func_i,
  input  wire logic [2:0]      sel_i,
  output wpscm_pkg::cmd_t      cmd_o,
  input  wire wpscm_pkg::sts_t sts_i
);
  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] STrk    = 4'd1;  // wait for track product
  localparam logic [3:0] SSecs   = 4'd2;
  localparam logic [3:0] SSecsW  = 4'd3;
  localparam logic [3:0] SMain   = 4'd4;
  localparam logic [3:0] SMainW  = 4'd5;
  localparam logic [3:0] SKilo   = 4'd6;  // wait for reciprocal product
  localparam logic [3:0] SKiloW  = 4'd7;
  localparam logic [3:0] SFinish = 4'd8;
  localparam logic [3:0] SOut    = 4'd9;
  localparam logic [3:0] SHold   = 4'd10;

  logic [3:0] st_q, st_d;
  logic [2:0] fn_q, fn_d, sl_q, sl_d;

  always_comb begin
    st_d = st_q; fn_d = fn_q; sl_d = sl_q; cmd_o = '0;
    in_ready_o = 1'b0;
    case (st_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          fn_d = func_i; sl_d = sel_i; cmd_o.event_en = 1'b1; st_d = STrk;
        end
      end
      STrk: begin
        if (fn_q == wpscm_pkg::FnReset) st_d = SKilo;
        else if (fn_q == wpscm_pkg::FnQuery) st_d = SSecs;
        else st_d = SOut;
      end
      SSecs: begin
        cmd_o.div_start = 1'b1; cmd_o.div_src = wpscm_pkg::DvTime; st_d = SSecsW;
      end
      SSecsW: if (sts_i.div_done) begin
        cmd_o.res_en = 1'b1; cmd_o.res_dst = wpscm_pkg::ResSecs; st_d = SKilo;
      end
      SKilo: st_d = SKiloW;
      SKiloW: begin
        cmd_o.res_en = 1'b1;
        cmd_o.res_dst = (fn_q == wpscm_pkg::FnReset) ? wpscm_pkg::ResAccum
                                                     : wpscm_pkg::ResDist;
        st_d = (fn_q == wpscm_pkg::FnReset) ? SOut : SMain;
      end
      SMain: begin
        cmd_o.val_direct = 1'b1;
        st_d = SFinish;
        if (sl_q == wpscm_pkg::QSpeed && sts_i.speed_ok) begin
          cmd_o.div_start = 1'b1; cmd_o.div_src = wpscm_pkg::DvSpeed; st_d = SMainW;
        end else if (sl_q == wpscm_pkg::QCadence && sts_i.cad_ok) begin
          cmd_o.div_start = 1'b1; cmd_o.div_src = wpscm_pkg::DvCadence; st_d = SMainW;
        end else if (sl_q == wpscm_pkg::QAvg && sts_i.secs_gt) begin
          cmd_o.div_start = 1'b1; cmd_o.div_src = wpscm_pkg::DvAvg; st_d = SMainW;
        end
      end
      SMainW: if (sts_i.div_done) begin
        cmd_o.res_en = 1'b1; cmd_o.res_dst = wpscm_pkg::ResValue; st_d = SFinish;
      end
      SFinish: st_d = SOut;
      SOut: begin
        cmd_o.out_load = 1'b1; st_d = SHold;
      end
      SHold: if (out_ready_i) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  assign out_valid_o = (st_q == SHold);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; fn_q <= '0; sl_q <= '0;
    end else begin
      st_q <= st_d; fn_q <= fn_d; sl_q <= sl_d;
    end
  end

`ifndef SYNTH
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("accept while result pending");
  a_start_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !cmd_o.res_en) else $error("start and capture together");
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_o) else $error("result not shown");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/wheel_pedal_speed_cadence_meter_top.sv =====
`default_nettype none
// Wheel/pedal speed and cadence meter. One transaction in gives one transaction out.
// A query runs the shared one-bit-per-cycle 32-bit divider for the seconds and,
// when valid, for speed, cadence or average; distance uses a reciprocal
// multiply. Configure only while idle.
module wheel_pedal_speed_cadence_meter_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata, // func, wheel_low, pedal_low, query_select
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [47:0]                        m_axis_tdata, // value, sleep_count, moving
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [wpscm_pkg::AddrW-1:0]   paddr,
  input  wire logic [wpscm_pkg::DataW-1:0]   pwdata,
  output logic [wpscm_pkg::DataW-1:0]        prdata,
  output logic                               pready
);
  logic [11:0] wl_q;
  logic [7:0]  deb_q, slp_q, sps_q;
  logic [15:0] avg_q;
  logic [31:0] value;
  logic [7:0]  sleep;
  logic        moving;
  logic [2:0]  ridx;
  wpscm_pkg::cmd_t cmd;
  wpscm_pkg::sts_t sts;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= wpscm_pkg::WheelLengthRst; deb_q <= wpscm_pkg::DebounceRst;
      slp_q <= wpscm_pkg::SleepRst; sps_q <= wpscm_pkg::StepsRst;
      avg_q <= wpscm_pkg::AvgMinRst;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        wpscm_pkg::RegWheel:  wl_q  <= pwdata[11:0];
        wpscm_pkg::RegDeb:    deb_q <= pwdata[7:0];
        wpscm_pkg::RegSleep:  slp_q <= pwdata[7:0];
        wpscm_pkg::RegSteps:  sps_q <= pwdata[7:0];
        wpscm_pkg::RegAvgMin: avg_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      wpscm_pkg::RegWheel:  prdata = {20'd0, wl_q};
      wpscm_pkg::RegDeb:    prdata = {24'd0, deb_q};
      wpscm_pkg::RegSleep:  prdata = {24'd0, slp_q};
      wpscm_pkg::RegSteps:  prdata = {24'd0, sps_q};
      wpscm_pkg::RegAvgMin: prdata = {16'd0, avg_q};
      default:              prdata = '0;
    endcase
  end

  logic [2:0] fn_lat, sel_lat;
  logic wl_lat, pl_lat;
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sel_lat <= s_axis_tdata[7:5];
    end
  end
  assign fn_lat = s_axis_tdata[2:0];
  assign wl_lat = s_axis_tdata[3];
  assign pl_lat = s_axis_tdata[4];

  wpscm_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .func_i(fn_lat), .wheel_low_i(wl_lat), .pedal_low_i(pl_lat), .sel_i(sel_lat),
    .wheel_length_i(wl_q), .debounce_i(deb_q), .sleep_reload_i(slp_q),
    .steps_i(sps_q), .avg_min_i(avg_q),
    .value_o(value), .sleep_o(sleep), .moving_o(moving)
  );

  wpscm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .func_i(s_axis_tdata[2:0]), .sel_i(s_axis_tdata[7:5]),
    .cmd_o(cmd), .sts_i(sts)
  );

  assign m_axis_tdata = {7'd0, moving, sleep, value};
endmodule
`default_nettype wire

// ===== dv/wheel_pedal_speed_cadence_meter_top_test.sv =====
`default_nettype none
module wheel_pedal_speed_cadence_meter_top_test;
  import wpscm_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // func, wheel_low, pedal_low, query_select
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;       // value, sleep_count, moving
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  wheel_pedal_speed_cadence_meter_top u_top (.*);

  always #10 clk_i = ~clk_i;

  typedef struct packed {
    logic [31:0] value;
    logic [7:0]  sleep;
    logic        moving;
  } meter_out_t;

  logic [7:0]  event_q[$];
  meter_out_t  reading_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_cycles = 0;
  int unsigned send_gap = 0, recv_gap = 0;

  // predictor state
  logic [11:0] r_wheel;
  logic [7:0]  r_deb, r_sleep, r_steps;
  logic [15:0] r_avgmin;
  logic [15:0] icount;
  logic [31:0] w_acc, p_acc, w_per, p_per, turns, tsteps, tdist;
  logic        moving, paused;
  logic [7:0]  w_hold, p_hold, sleep_cnt;

  function automatic logic [31:0] sdiv32(logic [31:0] a, logic [31:0] b);
    if (b == 0) return 0;
    if (b == 32'hFFFF_FFFF) return -a;
    return $signed(a) / $signed(b);
  endfunction

  function automatic logic [31:0] track_len();
    return turns * {20'd0, r_wheel};
  endfunction

  function automatic logic [31:0] track_secs();
    if (r_steps == 0) return 0;
    return sdiv32(tsteps, {24'd0, r_steps});
  endfunction

  function automatic logic [31:0] answer_query(qsel_e q);
    logic [31:0] s;
    case (q)
      QSpeed: return (moving && w_per != 0) ?
                sdiv32(SpeedScale * {20'd0, r_wheel}, w_per) : 32'd0;
      QTrack: return track_len();
      QTime: return track_secs();
      QAvg: begin
        s = track_secs();
        if ($signed(s) > $signed({16'd0, r_avgmin})) return sdiv32(track_len(), s);
        return -{24'd0, r_steps};
      end
      QCadence: return (moving && p_per != 0) ? sdiv32(CadenceConst, p_per) : 32'd0;
      QDist: return sdiv32(track_len(), KiloConst) + tdist;
      QWheel: return {20'd0, r_wheel};
      default: return 0;
    endcase
  endfunction

  task automatic apply_event(logic [7:0] d);
    func_e f;
    logic [31:0] v;
    f = func_e'(d[2:0]);
    v = 0;
    case (f)
      FnTick: begin
        icount = icount + 16'd1;
        if (icount == 0) begin
          w_acc = 0; p_acc = 0; w_per = 0; p_per = 0; moving = 0;
          if (sleep_cnt != 0) sleep_cnt--;
        end
      end
      FnPin: begin
        if (d[3] && w_hold == 0) begin
          w_hold = r_deb; turns++;
          if (moving) w_per = w_acc + icount;
          p_acc += icount; icount = 0; w_acc = 0;
        end
        if (d[4] && p_hold == 0) begin
          p_hold = r_deb;
          if (moving) p_per = p_acc + icount;
          w_acc += icount; icount = 0; p_acc = 0;
        end
        moving = 1; sleep_cnt = r_sleep;
      end
      FnStep: begin
        if (w_hold != 0) w_hold--;
        if (p_hold != 0) p_hold--;
        if (!paused && moving) tsteps++;
      end
      FnAct: sleep_cnt = r_sleep;
      FnPause: paused = ~paused;
      FnReset: begin
        paused = 0; tdist += sdiv32(track_len(), KiloConst); turns = 0; tsteps = 0;
      end
      FnQuery: v = answer_query(qsel_e'(d[7:5]));
      default: ;
    endcase
    reading_q.push_back('{value: v, sleep: sleep_cnt, moving: moving});
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_event(s_axis_tdata);
        event_q.pop_front();
      end
      if (s_axis_tvalid && !s_axis_tready) begin
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (event_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= event_q[0];
        send_gap <= ($urandom_range(0, 9) < 6) ? 0 :
                    ($urandom_range(0, 19) == 0 ? $urandom_range(20, 150)
                                                 : $urandom_range(1, 4));
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    meter_out_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{value: m_axis_tdata[31:0], sleep: m_axis_tdata[39:32],
                moving: m_axis_tdata[40]};
        if (reading_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction %h", m_axis_tdata);
        end else begin
          want = reading_q.pop_front();
          if (got != want || m_axis_tdata[47:41] != 0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp value %0d sleep %0d moving %0b, got %0d %0d %0b",
                       $signed(want.value), want.sleep, want.moving,
                       $signed(got.value), got.sleep, got.moving);
          end
        end
      end
      if (hold_cycles != 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_gap <= ($urandom_range(0, 9) < 7) ? 0 :
                    ($urandom_range(0, 19) == 0 ? $urandom_range(20, 150)
                                                 : $urandom_range(1, 4));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3_000_000) begin
      $display("[wheel_pedal_speed_cadence_meter_top] ERROR");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= AddrW'({idx, 2'b00}); pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      RegWheel: r_wheel = val[11:0];
      RegDeb: r_deb = val[7:0];
      RegSleep: r_sleep = val[7:0];
      RegSteps: r_steps = val[7:0];
      RegAvgMin: r_avgmin = val[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [7:0] mk(func_e f, logic w, logic p, qsel_e q);
    return {q, p, w, f};
  endfunction

  function automatic logic [7:0] rand_event();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 45) return mk(FnTick, 0, 0, qsel_e'($urandom_range(0, 7)));
    if (k < 58) return {3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), FnPin};
    if (k < 72) return mk(FnStep, 0, 0, QSpeed);
    if (k < 75) return mk(FnAct, 0, 0, QSpeed);
    if (k < 77) return mk(FnPause, 0, 0, QSpeed);
    if (k < 78) return mk(FnReset, 0, 0, QSpeed);
    if (k < 79) return {5'($urandom_range(0, 31)), FnNop};
    return mk(FnQuery, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              qsel_e'($urandom_range(0, 7)));
  endfunction

  task automatic drain();
    wait (event_q.size() == 0 && reading_q.size() == 0);
    repeat (150) @(posedge clk_i);
  endtask

  initial begin
    r_wheel = WheelLengthRst; r_deb = DebounceRst; r_sleep = SleepRst;
    r_steps = StepsRst; r_avgmin = AvgMinRst;
    icount = 0; w_acc = 0; p_acc = 0; w_per = 0; p_per = 0;
    turns = 0; tsteps = 0; tdist = 0; moving = 0; paused = 0;
    w_hold = r_deb; p_hold = r_deb; sleep_cnt = r_sleep;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    reg_write(RegDeb, 0);
    reg_write(RegSleep, 255);
    reg_write(RegWheel, 4095);
    reg_write(RegAvgMin, 0);
    reg_write(RegSteps, 1);
    // directed
    event_q.push_back(mk(FnQuery, 0, 0, QAvg));
    event_q.push_back(mk(FnPin, 1, 1, QSpeed));
    for (int i = 0; i < 5; i++) event_q.push_back(mk(FnTick, 0, 0, QSpeed));
    event_q.push_back(mk(FnPin, 1, 0, QSpeed));
    event_q.push_back(mk(FnTick, 0, 0, QSpeed));
    event_q.push_back(mk(FnPin, 0, 1, QSpeed));
    for (int i = 0; i < 3; i++) event_q.push_back(mk(FnStep, 0, 0, QSpeed));
    for (int q = 0; q < 8; q++) event_q.push_back(mk(FnQuery, 1, 1, qsel_e'(q)));
    event_q.push_back(mk(FnPause, 0, 0, QSpeed));
    event_q.push_back(mk(FnStep, 0, 0, QSpeed));
    event_q.push_back(mk(FnAct, 0, 0, QSpeed));
    event_q.push_back(mk(FnReset, 0, 0, QSpeed));
    event_q.push_back(mk(FnNop, 1, 1, QTrack));
    drain();
    // sleep reload of zero
    reg_write(RegSleep, 0);
    event_q.push_back(mk(FnAct, 0, 0, QSpeed));
    for (int i = 0; i < 8; i++) event_q.push_back(mk(FnTick, 0, 0, QSpeed));
    drain();
    reg_write(RegSteps, 0);
    event_q.push_back(mk(FnQuery, 0, 0, QAvg));
    event_q.push_back(mk(FnQuery, 0, 0, QTime));
    drain();
    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      reg_write(RegWheel, ph == 0 ? 0 : $urandom_range(0, 4095));
      reg_write(RegDeb, ph == 1 ? 255 : $urandom_range(0, 3));
      reg_write(RegSleep, ph == 2 ? 0 : $urandom_range(0, 255));
      reg_write(RegSteps, ph == 3 ? 255 : $urandom_range(1, 20));
      reg_write(RegAvgMin, ph == 3 ? 65535 : $urandom_range(0, 5));
      if (ph == 1) hold_cycles = 2000;
      for (int i = 0; i < 280; i++) event_q.push_back(rand_event());
      drain();
    end
    if (mismatches == 0) begin
      $display("[wheel_pedal_speed_cadence_meter_top] OK");
    end else begin
      $display("[wheel_pedal_speed_cadence_meter_top] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
